FILE: sv/palette_index_bit_packer_assert.svh
// Assertion macros of the palette index bit packer checker.
`ifndef PALETTE_INDEX_BIT_PACKER_ASSERT_SVH
`define PALETTE_INDEX_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: sv/pibp_pkg.sv
// Shared types, constants and helpers of the palette index bit packer.
package pibp_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int WORD_W            = 64;
    localparam int VALUE_W           = 16;
    localparam int BPE_W             = 5;
    localparam int POS_W             = 7;
    localparam int FIELD_MAX         = 16;

    localparam logic [1:0] OP_PACK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_IDX_BPE    = 1'b0;
    localparam logic REG_IDX_DIRECT = 1'b1;

    localparam logic [BPE_W-1:0] BPE_RESET = BPE_W'(4);

    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] value;
        logic               end_of_run;
    } pibp_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              last_word;
        logic              status;
    } pibp_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } pibp_state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic commit;
    } pibp_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic rd_pending;
        logic emit_needed;
        logic out_free;
    } pibp_status_t;

    // Effective field width: zero acts as one, anything above 16 acts as 16.
    function automatic logic [BPE_W-1:0] field_width(input logic [BPE_W-1:0] bpe);
        logic [BPE_W-1:0] w;
        w = bpe;
        if (bpe == '0) begin
            w = BPE_W'(1);
        end
        else if (bpe > BPE_W'(FIELD_MAX)) begin
            w = BPE_W'(FIELD_MAX);
        end
        return w;
    endfunction

endpackage

FILE: sv/pibp_ctrl.sv
// Controller state machine of the palette index bit packer.
module pibp_ctrl
    import pibp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  pibp_status_t status,
    output pibp_cmd_t    cmd
);

    pibp_state_t state_reg;
    pibp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // Issue one palette read per cycle, then wait for the last compare.
                cmd.issue = !status.issue_done;
                if (status.issue_done && !status.rd_pending)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!status.emit_needed || status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/pibp_datapath.sv
// Datapath of the palette index bit packer: palette store, rank search and word packing.
module pibp_datapath
    import pibp_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pibp_cmd_t        cmd,
    output pibp_status_t     status,
    input  pibp_req_t        req_data,
    input  logic [BPE_W-1:0] bits_per_entry,
    input  logic             direct_mode,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output pibp_rsp_t        rsp_data
);

    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [VALUE_W-1:0] palette_mem [PALETTE_DEPTH];

    pibp_req_t          item_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               rd_valid_reg,  rd_valid_next;
    logic [CNT_W-1:0]   idx_reg,       idx_next;
    logic               found_reg,     found_next;
    logic [CNT_W-1:0]   rank_reg,      rank_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [WORD_W-1:0]  acc_reg,       acc_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic               drop_reg,      drop_next;
    logic               rsp_valid_reg, rsp_valid_next;
    pibp_rsp_t          rsp_reg,       rsp_next;

    logic               need_search;
    logic               live_pack;
    logic               miss;
    logic [BPE_W-1:0]   width;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  field;
    logic [WORD_W-1:0]  acc_pack;
    logic [POS_W-1:0]   pos_sum;
    logic               word_done;
    logic               mem_we;
    logic               out_free;
    logic               load_rsp;

    // Decode of the request held for the current operation.
    assign live_pack   = (item_reg.operation == OP_PACK) && !drop_reg;
    assign need_search = (item_reg.operation == OP_LOAD) || (live_pack && !direct_mode);
    assign miss        = live_pack && !direct_mode && !found_reg;

    // Field placement.
    assign width    = field_width(bits_per_entry);
    assign mask     = (WORD_W'(1) << width) - WORD_W'(1);
    assign field    = (direct_mode ? WORD_W'(item_reg.value) : WORD_W'(rank_reg)) & mask;
    assign acc_pack = pos_reg[POS_W-1] ? acc_reg : (acc_reg | (field << pos_reg[POS_W-2:0]));
    assign pos_sum  = pos_reg + POS_W'(width);
    assign word_done = ({1'b0, pos_sum} + (POS_W + 1)'(width) > (POS_W + 1)'(WORD_W))
                       || item_reg.end_of_run;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign load_rsp = cmd.commit && live_pack && (miss || word_done);
    assign mem_we   = cmd.commit && (item_reg.operation == OP_LOAD) && !found_reg
                      && (count_reg < CNT_W'(PALETTE_DEPTH));

    assign status.issue_done  = !need_search || (idx_reg == count_reg);
    assign status.rd_pending  = rd_valid_reg;
    assign status.emit_needed = live_pack && (miss || word_done);
    assign status.out_free    = out_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_comb
    begin
        rd_valid_next  = cmd.issue;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        drop_next      = drop_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (cmd.accept)
        begin
            idx_next   = '0;
            found_next = 1'b0;
            rank_next  = '0;
        end
        if (cmd.issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (rd_valid_reg)
        begin
            if (rd_data_reg == item_reg.value)
            begin
                found_next = 1'b1;
            end
            else if (rd_data_reg < item_reg.value)
            begin
                rank_next = rank_reg + CNT_W'(1);
            end
        end

        if (cmd.commit)
        begin
            case (item_reg.operation)
                OP_LOAD:
                begin
                    if (mem_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_PACK:
                begin
                    if (drop_reg)
                    begin
                        if (item_reg.end_of_run)
                        begin
                            drop_next = 1'b0;
                        end
                    end
                    else if (miss)
                    begin
                        acc_next = '0;
                        pos_next = '0;
                        drop_next = !item_reg.end_of_run;
                        rsp_next.packed_word = '0;
                        rsp_next.last_word   = 1'b1;
                        rsp_next.status      = 1'b1;
                    end
                    else if (word_done)
                    begin
                        acc_next = '0;
                        pos_next = '0;
                        rsp_next.packed_word = acc_pack;
                        rsp_next.last_word   = item_reg.end_of_run;
                        rsp_next.status      = 1'b0;
                    end
                    else
                    begin
                        acc_next = acc_pack;
                        pos_next = pos_sum;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            rank_reg      <= '0;
            count_reg     <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            drop_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            rank_reg      <= rank_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            drop_reg      <= drop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_data;
        end
        rsp_reg <= rsp_next;
    end

    // Palette store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[count_reg[ADDR_W-1:0]] <= item_reg.value;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= palette_mem[idx_reg[ADDR_W-1:0]];
        end
    end

endmodule

FILE: sv/palette_index_bit_packer.sv
// Top level of the palette index bit packer: configuration registers and block assembly.
//
// This block packs a run of 16-bit values into 64-bit words, placing fields of
// bits_per_entry bits from bit 0 upward without ever splitting a field across two
// words. A word is sent when the next field would not fit, and the partial word
// is sent with the value that ends the run, marked last_word. In indirect mode each
// value is replaced by its rank among the palette entries loaded earlier; a value
// that is missing from the palette produces an error response marked last, and the
// rest of that run is dropped. Requests are handled one at a time. A pack request
// in indirect mode and a palette load both scan the palette store through its
// single read port at one entry per cycle, covering every entry below the fill count.
// A request that produces a response waits while the previous response is still
// held by the downstream side. The next request is accepted as soon as the
// previous one has been handed to the output register, even while that response
// is still waiting to be taken. The palette store needs no clearing after reset,
// because only entries below the fill count are ever read. Configuration is
// written through the APB port; the user must write it only while the block is
// idle, as the block itself does not enforce this. bits_per_entry sits at byte
// address 0 and direct_mode at byte address 4.
module palette_index_bit_packer
    import pibp_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Request channel.
    input  logic        req_valid,
    output logic        req_ready,
    input  pibp_req_t   req_data,

    // Response channel.
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output pibp_rsp_t   rsp_data,

    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BPE_W-1:0] bpe_reg, bpe_next;
    logic             direct_reg, direct_next;
    logic             cfg_write;
    logic             reg_idx;

    pibp_cmd_t    cmd;
    pibp_status_t status;

    // The register index is the word address; the low byte-offset bits are ignored.
    assign reg_idx   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        bpe_next    = bpe_reg;
        direct_next = direct_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_IDX_BPE:
                begin
                    bpe_next = pwdata[BPE_W-1:0];
                end
                REG_IDX_DIRECT:
                begin
                    direct_next = pwdata[0];
                end
                default:
                begin
                    bpe_next = bpe_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IDX_BPE:
            begin
                prdata = 32'(bpe_reg);
            end
            REG_IDX_DIRECT:
            begin
                prdata = 32'(direct_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg    <= BPE_RESET;
            direct_reg <= 1'b0;
        end
        else
        begin
            bpe_reg    <= bpe_next;
            direct_reg <= direct_next;
        end
    end

    // The controller sequences each request; the datapath holds the palette, packing and response state.
    pibp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pibp_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .req_data       (req_data),
        .bits_per_entry (bpe_reg),
        .direct_mode    (direct_reg),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_data       (rsp_data)
    );

endmodule

FILE: sv/pibp_checker.sv
// Port-level assertion checker of the palette index bit packer and its bind.
`include "palette_index_bit_packer_assert.svh"

module pibp_checker
    import pibp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input pibp_rsp_t rsp_data
);

    logic word_empty;

    assign word_empty = (rsp_data.packed_word == '0);

    // A stalled response holds its value.
    `PIBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

    // An error response always closes the run and carries an empty word.
    `PIBP_ASSERT_NOW(a_err_last, rsp_valid && rsp_data.status, rsp_data.last_word && word_empty)

    // Requests are handled one at a time, so an accepted request blocks the next cycle.
    `PIBP_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

    // A fresh response only appears after a request has been in progress.
    `PIBP_ASSERT_NOW(a_rsp_after_work, $rose(rsp_valid), $past(!req_ready))

endmodule

bind palette_index_bit_packer pibp_checker u_pibp_checker (.*);
